// File: src/i2c_slave_buffer_engine_macros.svh
// assertion macros for the i2c slave buffer engine
// used by the top level only; expects clk and arst_n in scope
`ifndef I2C_SLAVE_BUFFER_ENGINE_MACROS_SVH
`define I2C_SLAVE_BUFFER_ENGINE_MACROS_SVH

// property that holds at every edge out of reset
`define SBE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication
`define SBE_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SBE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/i2csbe_pkg.sv
// shared types and constants of the i2c slave buffer engine
// no dependencies
package i2csbe_pkg;

	localparam int BUFFER_DEPTH = 16;
	localparam int AW           = $clog2(BUFFER_DEPTH);
	localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);
	localparam int RX_COUNT_W   = 5;

	// twi slave status codes
	localparam logic [7:0] ST_SLA_W_ACK    = 8'h60;
	localparam logic [7:0] ST_DATA_RX_ACK  = 8'h80;
	localparam logic [7:0] ST_STOP_RESTART = 8'hA0;
	localparam logic [7:0] ST_SLA_R_ACK    = 8'hA8;
	localparam logic [7:0] ST_DATA_TX_ACK  = 8'hB8;
	localparam logic [7:0] ST_DATA_TX_NACK = 8'hC0;
	localparam logic [7:0] ST_LAST_TX_ACK  = 8'hC8;

	typedef enum logic [1:0] {
		OP_BUS_EVENT  = 2'd0,
		OP_PUSH_TX    = 2'd1,
		OP_RESTART_TX = 2'd2,
		OP_READ_RX    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ERR_OK        = 2'd0,
		ERR_BUSY      = 2'd1,
		ERR_RANGE     = 2'd2,
		ERR_NOT_READY = 2'd3
	} err_t;

	typedef struct packed {
		logic       rx_complete;
		logic       rx_busy;
		logic       tx_complete;
		logic       tx_aborted;
		logic       tx_busy;
	} flags_t;

	// input tdata, lowest field in the lowest bits
	typedef struct packed {
		logic [3:0] pad;
		logic [3:0] read_index;
		logic [7:0] host_byte;
		logic [7:0] received_byte;
		logic [7:0] bus_status;
	} item_t;

	// output tdata, lowest field in the lowest bits
	typedef struct packed {
		logic [1:0]            pad;
		logic                  rx_complete_flag;
		logic                  rx_busy_flag;
		logic                  tx_complete_flag;
		logic                  tx_aborted_flag;
		logic                  tx_busy_flag;
		logic [RX_COUNT_W-1:0] rx_count;
		logic [7:0]            read_byte;
		logic [1:0]            error_code;
		logic [7:0]            send_byte;
		logic                  send_valid;
		logic                  ack_next;
	} result_t;

endpackage

// File: src/i2csbe_ram.sv
// simple dual-port synchronous ram, one write and one registered read port
// no dependencies
module i2csbe_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: src/i2c_slave_buffer_engine.sv
// i2c slave buffer engine: twi status events and host accesses on the transmit/receive stores
// a transaction is accepted only in the idle state and held with the store read data registered;
// the execute state then registers its result into the output register, and no new transaction
// is taken until it commits; a stalled output holds the engine in its execute state
// reset (arst_n, asynchronous): pointers, lengths and flags clear; store contents undefined
// depends on i2csbe_pkg, i2csbe_ram and i2c_slave_buffer_engine_macros.svh
`include "i2c_slave_buffer_engine_macros.svh"

module i2c_slave_buffer_engine (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // bus_status, received_byte, host_byte, read_index, zero pad
	input  logic [1:0]  s_tuser,  // op
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata   // ack_next, send_valid, send_byte, error_code, read_byte,
	                              // rx_count, tx_busy_flag, tx_aborted_flag, tx_complete_flag,
	                              // rx_busy_flag, rx_complete_flag, zero pad
);

	localparam int AW    = i2csbe_pkg::AW;
	localparam int CNT_W = i2csbe_pkg::CNT_W;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t                     state_q;
	i2csbe_pkg::item_t          item_s1;
	i2csbe_pkg::op_t            op_s1;
	i2csbe_pkg::result_t        m_tdata_q;
	logic                       m_tvalid_q;

	// engine state outside the stores
	logic [CNT_W-1:0]           tx_len_q,  tx_len_nxt;
	logic [CNT_W-1:0]           tx_pos_q,  tx_pos_nxt;
	logic [CNT_W-1:0]           rx_pos_q,  rx_pos_nxt;
	logic [CNT_W-1:0]           rx_len_q,  rx_len_nxt;
	i2csbe_pkg::flags_t         flags_q,   flags_nxt;

	i2csbe_pkg::item_t          in_item;
	i2csbe_pkg::result_t        res;
	logic                       s_fire;
	logic                       exec_fire;
	logic [CNT_W-1:0]           tx_adv;

	// store ports
	logic                       tx_we, rx_we;
	logic [AW-1:0]              tx_waddr, rx_waddr, tx_raddr, rx_raddr;
	logic [7:0]                 tx_wdata, rx_wdata, tx_rdata, rx_rdata;

	// entry lookup for the master read path
	logic                       tx_sel;
	logic [CNT_W-1:0]           entry_pos;

	assign in_item   = i2csbe_pkg::item_t'(s_tdata);
	assign s_tready  = (state_q == ST_IDLE);
	assign s_fire    = s_tvalid && s_tready;
	// the execute cycle commits only when the output register is free or being emptied
	assign exec_fire = (state_q == ST_EXEC) && (!m_tvalid_q || m_tready);

	// tx pointer after a data-acknowledged event, saturating at the depth
	assign tx_adv = (tx_pos_q < CNT_W'(i2csbe_pkg::BUFFER_DEPTH)) ?
		tx_pos_q + CNT_W'(1) : tx_pos_q;

	// read addresses are taken from the arriving transaction and the unchanged state
	always_comb begin
		tx_raddr = '0;
		if (in_item.bus_status == i2csbe_pkg::ST_DATA_TX_ACK) begin
			tx_raddr = tx_adv[AW-1:0];
		end
	end
	assign rx_raddr = AW'(in_item.read_index);

	i2csbe_ram #(
		.DEPTH (i2csbe_pkg::BUFFER_DEPTH),
		.WIDTH (8)
	) u_tx_store (
		.clk   (clk),
		.we    (tx_we),
		.waddr (tx_waddr),
		.wdata (tx_wdata),
		.re    (s_fire),
		.raddr (tx_raddr),
		.rdata (tx_rdata)
	);

	i2csbe_ram #(
		.DEPTH (i2csbe_pkg::BUFFER_DEPTH),
		.WIDTH (8)
	) u_rx_store (
		.clk   (clk),
		.we    (rx_we),
		.waddr (rx_waddr),
		.wdata (rx_wdata),
		.re    (s_fire),
		.raddr (rx_raddr),
		.rdata (rx_rdata)
	);

	// execute: decode the held transaction against the store read data
	always_comb begin
		tx_len_nxt = tx_len_q;
		tx_pos_nxt = tx_pos_q;
		rx_pos_nxt = rx_pos_q;
		rx_len_nxt = rx_len_q;
		flags_nxt  = flags_q;
		res        = '0;
		tx_we      = 1'b0;
		rx_we      = 1'b0;
		tx_waddr   = tx_len_q[AW-1:0];
		rx_waddr   = rx_pos_q[AW-1:0];
		tx_wdata   = item_s1.host_byte;
		rx_wdata   = item_s1.received_byte;
		tx_sel     = 1'b0;
		entry_pos  = '0;

		unique case (op_s1)
			i2csbe_pkg::OP_BUS_EVENT: begin
				res.ack_next = 1'b1;
				unique case (item_s1.bus_status)
					i2csbe_pkg::ST_SLA_W_ACK: begin
						rx_pos_nxt        = '0;
						flags_nxt.rx_busy = 1'b1;
					end
					i2csbe_pkg::ST_DATA_RX_ACK: begin
						if (rx_pos_q < CNT_W'(i2csbe_pkg::BUFFER_DEPTH)) begin
							rx_we        = 1'b1;
							rx_pos_nxt   = rx_pos_q + CNT_W'(1);
							res.ack_next = (rx_pos_nxt < CNT_W'(i2csbe_pkg::BUFFER_DEPTH));
						end else begin
							// no room: byte dropped
							res.ack_next = 1'b0;
						end
					end
					i2csbe_pkg::ST_STOP_RESTART: begin
						flags_nxt.rx_busy     = 1'b0;
						flags_nxt.rx_complete = 1'b1;
						rx_len_nxt            = rx_pos_q;
					end
					i2csbe_pkg::ST_SLA_R_ACK: begin
						flags_nxt.tx_busy = 1'b1;
						tx_pos_nxt        = '0;
						tx_sel            = 1'b1;
						entry_pos         = '0;
					end
					i2csbe_pkg::ST_DATA_TX_ACK: begin
						tx_pos_nxt = tx_adv;
						tx_sel     = 1'b1;
						entry_pos  = tx_adv;
					end
					i2csbe_pkg::ST_DATA_TX_NACK: begin
						flags_nxt.tx_busy    = 1'b0;
						flags_nxt.tx_aborted = 1'b1;
					end
					i2csbe_pkg::ST_LAST_TX_ACK: begin
						flags_nxt.tx_busy     = 1'b0;
						flags_nxt.tx_complete = 1'b1;
					end
					default: begin
						// other status codes leave the state alone
					end
				endcase
			end
			i2csbe_pkg::OP_PUSH_TX: begin
				if (flags_q.tx_busy) begin
					res.error_code = i2csbe_pkg::ERR_BUSY;
				end else if (tx_len_q >= CNT_W'(i2csbe_pkg::BUFFER_DEPTH)) begin
					res.error_code = i2csbe_pkg::ERR_RANGE;
				end else begin
					tx_we      = 1'b1;
					tx_len_nxt = tx_len_q + CNT_W'(1);
				end
			end
			i2csbe_pkg::OP_RESTART_TX: begin
				if (flags_q.tx_busy) begin
					res.error_code = i2csbe_pkg::ERR_BUSY;
				end else begin
					tx_len_nxt            = '0;
					tx_pos_nxt            = '0;
					flags_nxt.tx_aborted  = 1'b0;
					flags_nxt.tx_complete = 1'b0;
				end
			end
			i2csbe_pkg::OP_READ_RX: begin
				if (flags_q.rx_busy) begin
					res.error_code = i2csbe_pkg::ERR_BUSY;
				end else if (!flags_q.rx_complete) begin
					res.error_code = i2csbe_pkg::ERR_NOT_READY;
				end else if (CNT_W'(item_s1.read_index) >= rx_len_q) begin
					res.error_code = i2csbe_pkg::ERR_RANGE;
				end else begin
					res.read_byte = rx_rdata;
				end
			end
			default: begin
			end
		endcase

		// byte for the master: a stored entry, or 0xff once the store runs dry
		if (tx_sel) begin
			res.send_valid = 1'b1;
			if (entry_pos < tx_len_q) begin
				res.send_byte = tx_rdata;
				res.ack_next  = (entry_pos + CNT_W'(1) < tx_len_q);
			end else begin
				res.send_byte = 8'hFF;
				res.ack_next  = 1'b0;
			end
		end

		res.rx_count         = i2csbe_pkg::RX_COUNT_W'(rx_len_nxt);
		res.tx_busy_flag     = flags_nxt.tx_busy;
		res.tx_aborted_flag  = flags_nxt.tx_aborted;
		res.tx_complete_flag = flags_nxt.tx_complete;
		res.rx_busy_flag     = flags_nxt.rx_busy;
		res.rx_complete_flag = flags_nxt.rx_complete;

		// writes land only in a committing execute cycle
		tx_we = tx_we && exec_fire;
		rx_we = rx_we && exec_fire;
	end

	// control state, held transaction and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			item_s1    <= '0;
			op_s1      <= i2csbe_pkg::OP_BUS_EVENT;
			tx_len_q   <= '0;
			tx_pos_q   <= '0;
			rx_pos_q   <= '0;
			rx_len_q   <= '0;
			flags_q    <= '0;
		end else begin
			// drained and not refilled in the same cycle
			if (m_tvalid_q && m_tready && !exec_fire) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_fire) begin
						item_s1 <= in_item;
						op_s1   <= i2csbe_pkg::op_t'(s_tuser);
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (exec_fire) begin
						tx_len_q   <= tx_len_nxt;
						tx_pos_q   <= tx_pos_nxt;
						rx_pos_q   <= rx_pos_nxt;
						rx_len_q   <= rx_len_nxt;
						flags_q    <= flags_nxt;
						m_tdata_q  <= res;
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// pointers and lengths never pass the store depth
	`SBE_ASSERT(a_ptr_range, (tx_pos_q <= CNT_W'(i2csbe_pkg::BUFFER_DEPTH)) && (tx_len_q <= CNT_W'(i2csbe_pkg::BUFFER_DEPTH)) && (rx_pos_q <= CNT_W'(i2csbe_pkg::BUFFER_DEPTH)) && (rx_len_q <= CNT_W'(i2csbe_pkg::BUFFER_DEPTH)), "pointer or length beyond store depth")
	// an accepted transaction puts the engine in its execute state in the following cycle
	`SBE_ASSERT_NEXT(a_accept_exec, s_fire, state_q == ST_EXEC, "accepted transaction not executed")
	// store writes only happen while a transaction commits
	`SBE_ASSERT_IMPL(a_write_exec, tx_we || rx_we, exec_fire, "store written outside execute")
	// a result with nothing to send carries a zero send byte
	`SBE_ASSERT_IMPL(a_send_zero, m_tvalid_q && !m_tdata_q.send_valid, m_tdata_q.send_byte == 8'h00, "send byte set without send valid")

endmodule

// File: test/i2c_slave_buffer_engine_test.sv
// self-checking testbench of the i2c slave buffer engine: bus events and host accesses
// on the input stream, every result compared against a cycle-free predictor of the engine
// depends on i2csbe_pkg and the i2c_slave_buffer_engine top level
`timescale 1ns / 100ps

module i2c_slave_buffer_engine_test;

	// predictor of the engine plus the queue of results still owed by the block
	class engine_scoreboard;
		bit [7:0]                 tx_mem [i2csbe_pkg::BUFFER_DEPTH];
		bit [7:0]                 rx_mem [i2csbe_pkg::BUFFER_DEPTH];
		int                       tx_len;
		int                       tx_pos;
		int                       rx_pos;
		int                       rx_len;
		i2csbe_pkg::flags_t       flags;
		i2csbe_pkg::result_t      pending_responses [$];
		int                       op_seen [4];
		int                       tx_full_hits;
		int                       rx_overflow_hits;
		int                       checked;

		function new();
			flags = '0;
			tx_len = 0;
			tx_pos = 0;
			rx_pos = 0;
			rx_len = 0;
			tx_full_hits = 0;
			rx_overflow_hits = 0;
			checked = 0;
			foreach (op_seen[i]) op_seen[i] = 0;
		endfunction

		// byte the master reads at the current transmit position, 0xff past the end
		function void fill_send(inout i2csbe_pkg::result_t r);
			r.send_valid = 1'b1;
			if (tx_pos < tx_len && tx_pos < i2csbe_pkg::BUFFER_DEPTH) begin
				r.send_byte = tx_mem[tx_pos];
				r.ack_next  = (tx_pos + 1 < tx_len);
			end else begin
				r.send_byte = 8'hFF;
				r.ack_next  = 1'b0;
			end
		endfunction

		function i2csbe_pkg::result_t next_response(i2csbe_pkg::op_t op, i2csbe_pkg::item_t d);
			i2csbe_pkg::result_t r;
			i2csbe_pkg::err_t    err;
			r = '0;
			err = i2csbe_pkg::ERR_OK;
			case (op)
				i2csbe_pkg::OP_BUS_EVENT: begin
					r.ack_next = 1'b1;
					case (d.bus_status)
						i2csbe_pkg::ST_SLA_W_ACK: begin
							rx_pos = 0;
							flags.rx_busy = 1'b1;
						end
						i2csbe_pkg::ST_DATA_RX_ACK: begin
							if (rx_pos < i2csbe_pkg::BUFFER_DEPTH) begin
								rx_mem[rx_pos] = d.received_byte;
								rx_pos++;
								r.ack_next = (rx_pos < i2csbe_pkg::BUFFER_DEPTH);
							end else begin
								// no room left, byte dropped
								r.ack_next = 1'b0;
								rx_overflow_hits++;
							end
						end
						i2csbe_pkg::ST_STOP_RESTART: begin
							flags.rx_busy = 1'b0;
							rx_len = rx_pos;
							flags.rx_complete = 1'b1;
						end
						i2csbe_pkg::ST_SLA_R_ACK: begin
							flags.tx_busy = 1'b1;
							tx_pos = 0;
							fill_send(r);
						end
						i2csbe_pkg::ST_DATA_TX_ACK: begin
							if (tx_pos < i2csbe_pkg::BUFFER_DEPTH) tx_pos++;
							fill_send(r);
						end
						i2csbe_pkg::ST_DATA_TX_NACK: begin
							flags.tx_busy = 1'b0;
							flags.tx_aborted = 1'b1;
						end
						i2csbe_pkg::ST_LAST_TX_ACK: begin
							flags.tx_busy = 1'b0;
							flags.tx_complete = 1'b1;
						end
						default: ;
					endcase
				end
				i2csbe_pkg::OP_PUSH_TX: begin
					if (flags.tx_busy) begin
						err = i2csbe_pkg::ERR_BUSY;
					end else if (tx_len >= i2csbe_pkg::BUFFER_DEPTH) begin
						err = i2csbe_pkg::ERR_RANGE;
						tx_full_hits++;
					end else begin
						tx_mem[tx_len] = d.host_byte;
						tx_len++;
					end
				end
				i2csbe_pkg::OP_RESTART_TX: begin
					if (flags.tx_busy) begin
						err = i2csbe_pkg::ERR_BUSY;
					end else begin
						tx_len = 0;
						tx_pos = 0;
						flags.tx_aborted = 1'b0;
						flags.tx_complete = 1'b0;
					end
				end
				default: begin
					if (flags.rx_busy) err = i2csbe_pkg::ERR_BUSY;
					else if (!flags.rx_complete) err = i2csbe_pkg::ERR_NOT_READY;
					else if (d.read_index >= rx_len) err = i2csbe_pkg::ERR_RANGE;
					else r.read_byte = rx_mem[d.read_index];
				end
			endcase
			r.error_code       = err;
			r.rx_count         = rx_len[i2csbe_pkg::RX_COUNT_W-1:0];
			r.tx_busy_flag     = flags.tx_busy;
			r.tx_aborted_flag  = flags.tx_aborted;
			r.tx_complete_flag = flags.tx_complete;
			r.rx_busy_flag     = flags.rx_busy;
			r.rx_complete_flag = flags.rx_complete;
			return r;
		endfunction

		function void log_request(i2csbe_pkg::op_t op, i2csbe_pkg::item_t d);
			op_seen[op]++;
			pending_responses.push_back(next_response(op, d));
		endfunction

		// empty string when the result matches the oldest outstanding one
		function string check_response(i2csbe_pkg::result_t got);
			i2csbe_pkg::result_t want;
			string   bad;
			checked++;
			if (pending_responses.size() == 0)
				return $sformatf("result %h arrived with nothing outstanding", got);
			want = pending_responses.pop_front();
			bad = "";
			if (got.ack_next !== want.ack_next) bad = {bad, " ack_next"};
			if (got.send_valid !== want.send_valid) bad = {bad, " send_valid"};
			if (got.send_byte !== want.send_byte) bad = {bad, " send_byte"};
			if (got.error_code !== want.error_code) bad = {bad, " error_code"};
			if (got.read_byte !== want.read_byte) bad = {bad, " read_byte"};
			if (got.rx_count !== want.rx_count) bad = {bad, " rx_count"};
			if (got.tx_busy_flag !== want.tx_busy_flag) bad = {bad, " tx_busy_flag"};
			if (got.tx_aborted_flag !== want.tx_aborted_flag) bad = {bad, " tx_aborted_flag"};
			if (got.tx_complete_flag !== want.tx_complete_flag) bad = {bad, " tx_complete_flag"};
			if (got.rx_busy_flag !== want.rx_busy_flag) bad = {bad, " rx_busy_flag"};
			if (got.rx_complete_flag !== want.rx_complete_flag) bad = {bad, " rx_complete_flag"};
			if (got.pad !== want.pad) bad = {bad, " pad"};
			if (bad == "") return "";
			return $sformatf("result %0d wrong:%s (expected %h, got %h)", checked, bad, want, got);
		endfunction

		function int pending();
			return pending_responses.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;   // bus_status, received_byte, host_byte, read_index, zero pad
	logic [1:0]  s_tuser = '0;   // op
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;        // ack_next, send_valid, send_byte, error_code, read_byte,
	                             // rx_count, five status flags, zero pad

	engine_scoreboard sb = new();
	int    mismatches = 0;
	int    items_sent = 0;
	bit    quiet = 1'b0;         // no new idle stretches on either side while set
	int    hold_request = 0;     // long receiver hold-off asked by the stimulus
	int    hold_left = 0;
	int    stall_left = 0;
	int    guard;
	int    target;
	string why;

	i2c_slave_buffer_engine uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("error at %0t: %s", $realtime, msg);
	endtask

	// mostly short idle stretches, now and then a long one
	function automatic int idle_length();
		if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	// entered just after the edge that took the previous transaction
	task automatic send_item(input i2csbe_pkg::op_t op, input i2csbe_pkg::item_t d);
		int gap;
		gap = (quiet || hold_left > 0 || $urandom_range(0, 99) < 50) ? 0 : idle_length();
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		s_tuser  <= op;
		do @(posedge clk); while (!s_tready);
		sb.log_request(op, d);
		items_sent++;
	endtask

	// unused fields carry random content; the pad stays zero
	function automatic i2csbe_pkg::item_t random_item();
		i2csbe_pkg::item_t d;
		d = $urandom;
		d.pad = '0;
		return d;
	endfunction

	task automatic bus_event(input logic [7:0] code, input logic [7:0] rx_byte);
		i2csbe_pkg::item_t d;
		d = random_item();
		d.bus_status = code;
		d.received_byte = rx_byte;
		send_item(i2csbe_pkg::OP_BUS_EVENT, d);
	endtask

	task automatic push_byte(input logic [7:0] value);
		i2csbe_pkg::item_t d;
		d = random_item();
		d.host_byte = value;
		send_item(i2csbe_pkg::OP_PUSH_TX, d);
	endtask

	task automatic restart_tx();
		send_item(i2csbe_pkg::OP_RESTART_TX, random_item());
	endtask

	task automatic read_rx(input logic [3:0] index);
		i2csbe_pkg::item_t d;
		d = random_item();
		d.read_index = index;
		send_item(i2csbe_pkg::OP_READ_RX, d);
	endtask

	// master write: address, data bytes, usually a stop
	task automatic master_write();
		int n;
		n = ($urandom_range(0, 99) < 30) ? $urandom_range(14, 18) : $urandom_range(0, 6);
		bus_event(i2csbe_pkg::ST_SLA_W_ACK, 8'($urandom));
		repeat (n) bus_event(i2csbe_pkg::ST_DATA_RX_ACK, 8'($urandom));
		if ($urandom_range(0, 99) < 85) bus_event(i2csbe_pkg::ST_STOP_RESTART, 8'($urandom));
	endtask

	// master read: address, acknowledged bytes, then last-byte ack, nack or nothing
	task automatic master_read();
		int k;
		int ending;
		k = ($urandom_range(0, 99) < 20) ? $urandom_range(14, 17) : $urandom_range(0, 4);
		bus_event(i2csbe_pkg::ST_SLA_R_ACK, 8'($urandom));
		repeat (k) bus_event(i2csbe_pkg::ST_DATA_TX_ACK, 8'($urandom));
		ending = $urandom_range(0, 99);
		if (ending < 45) bus_event(i2csbe_pkg::ST_LAST_TX_ACK, 8'($urandom));
		else if (ending < 85) bus_event(i2csbe_pkg::ST_DATA_TX_NACK, 8'($urandom));
	endtask

	// host refills the transmit store, sometimes past its capacity
	task automatic host_load();
		int m;
		m = ($urandom_range(0, 99) < 30) ? $urandom_range(14, 17) : $urandom_range(0, 5);
		if ($urandom_range(0, 99) < 85) restart_tx();
		repeat (m) push_byte(8'($urandom));
	endtask

	task automatic host_reads();
		repeat ($urandom_range(1, 5)) begin
			if ($urandom_range(0, 1)) read_rx(4'($urandom));
			else read_rx(4'($urandom_range(0, 3)));
		end
	endtask

	// status codes of the protocol in no particular order, plus stray codes
	task automatic broken_sequence();
		logic [7:0] codes [9];
		codes = '{i2csbe_pkg::ST_SLA_W_ACK, i2csbe_pkg::ST_DATA_RX_ACK,
			i2csbe_pkg::ST_STOP_RESTART, i2csbe_pkg::ST_SLA_R_ACK,
			i2csbe_pkg::ST_DATA_TX_ACK, i2csbe_pkg::ST_DATA_TX_NACK,
			i2csbe_pkg::ST_LAST_TX_ACK, 8'h68, 8'h00};
		repeat ($urandom_range(1, 6)) begin
			if ($urandom_range(0, 9) == 0) bus_event(8'($urandom), 8'($urandom));
			else bus_event(codes[$urandom_range(0, 8)], 8'($urandom));
		end
	endtask

	task automatic noise();
		repeat ($urandom_range(1, 4))
			send_item(i2csbe_pkg::op_t'($urandom_range(0, 3)), random_item());
	endtask

	// receiver: random stalls, plus the long hold-off counted here
	initial begin
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if (!quiet && $urandom_range(0, 99) < 20) begin
				m_tready <= 1'b0;
				stall_left = idle_length() - 1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// result check at every accepted output transaction
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			why = sb.check_response(i2csbe_pkg::result_t'(m_tdata));
			if (why != "") report_mismatch(why);
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reads before any receive, stray codes, empty and short transmit
		read_rx(4'd0);
		bus_event(8'h00, 8'h00);
		bus_event(8'hFF, 8'hFF);
		bus_event(8'h68, 8'h5A);
		bus_event(i2csbe_pkg::ST_SLA_R_ACK, 8'h00);
		bus_event(i2csbe_pkg::ST_DATA_TX_ACK, 8'h00);
		bus_event(i2csbe_pkg::ST_DATA_TX_NACK, 8'h00);
		push_byte(8'hFF);
		push_byte(8'h00);
		bus_event(i2csbe_pkg::ST_SLA_R_ACK, 8'h00);
		push_byte(8'hA5);
		restart_tx();
		bus_event(i2csbe_pkg::ST_DATA_TX_ACK, 8'h00);
		bus_event(i2csbe_pkg::ST_DATA_TX_ACK, 8'h00);
		bus_event(i2csbe_pkg::ST_LAST_TX_ACK, 8'h00);
		restart_tx();
		// directed: a two-byte master write, read while busy, then reads in and out of range
		bus_event(i2csbe_pkg::ST_SLA_W_ACK, 8'h00);
		bus_event(i2csbe_pkg::ST_DATA_RX_ACK, 8'hFF);
		read_rx(4'd0);
		bus_event(i2csbe_pkg::ST_DATA_RX_ACK, 8'h00);
		bus_event(i2csbe_pkg::ST_STOP_RESTART, 8'h00);
		read_rx(4'd0);
		read_rx(4'd1);
		read_rx(4'd15);

		// random: mostly well-formed bus and host sequences, some noise
		target = items_sent + 1050;
		while (items_sent < target) begin
			quiet = (items_sent >= target - 750 && items_sent < target - 650);
			if (hold_request == 0 && hold_left == 0 && items_sent >= target - 450
				&& items_sent < target - 440)
				hold_request = 300;
			case ($urandom_range(0, 9))
				0, 1: master_write();
				2, 3: master_read();
				4, 5: host_load();
				6, 7: host_reads();
				8: broken_sequence();
				default: noise();
			endcase
		end
		@(negedge clk);
		s_tvalid <= 1'b0;

		guard = 0;
		while (sb.pending() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (20) @(posedge clk);
		if (sb.pending() != 0)
			report_mismatch($sformatf("%0d expected results never arrived", sb.pending()));

		$display("covered %0d transactions: %0d bus events, %0d pushes, %0d restarts, %0d reads",
			items_sent, sb.op_seen[i2csbe_pkg::OP_BUS_EVENT], sb.op_seen[i2csbe_pkg::OP_PUSH_TX],
			sb.op_seen[i2csbe_pkg::OP_RESTART_TX], sb.op_seen[i2csbe_pkg::OP_READ_RX]);
		$display("%0d results compared, %0d pushes to a full store, %0d bytes dropped on overflow",
			sb.checked, sb.tx_full_hits, sb.rx_overflow_hits);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// overall time limit
	initial begin
		#10_000_000;
		$display("timeout with %0d results outstanding", sb.pending());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+src
src/i2csbe_pkg.sv
src/i2csbe_ram.sv
src/i2c_slave_buffer_engine.sv
test/i2c_slave_buffer_engine_test.sv
